### design/drls_pkg.sv
// ----------------------------------------------------------------------------
// drls_pkg
// Types and constants shared by the display RAM load sequencer modules.
// ----------------------------------------------------------------------------
package drls_pkg;

  localparam int PosWidth  = 9;
  localparam int PosLimit  = 512;
  localparam int MaxPages  = 13;
  localparam int ColWidth  = 8;
  localparam int PageWidth = 4;

  // Controller address offset that skips the frame
  localparam int AddrOffset = 2;

  // Descriptor queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Command codes
  localparam logic [7:0] CmdRemapOn  = 8'hA1;
  localparam logic [7:0] CmdRemapOff = 8'hA0;
  localparam logic [7:0] CmdColHigh  = 8'h10;
  localparam logic [7:0] CmdColLow   = 8'h00;
  localparam logic [7:0] CmdPage     = 8'hB0;
  localparam logic [7:0] CmdNop      = 8'hE3;

  // Positions of the result slots in the burst mask, in emission order
  localparam int SlotRemap   = 0;
  localparam int SlotColHigh = 1;
  localparam int SlotColLow  = 2;
  localparam int SlotPage    = 3;
  localparam int SlotData    = 4;
  localparam int SlotNop     = 5;
  localparam int NumSlots    = 6;

  typedef struct packed {
    logic [7:0]           pixel;
    logic                 first;
    logic                 address;
    logic                 last;
    logic                 remap;
    logic [ColWidth-1:0]  col_addr;
    logic [PageWidth-1:0] page_addr;
  } drls_desc_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } drls_head_ctrl_t;

endpackage

### design/drls_if.sv
// ----------------------------------------------------------------------------
// drls_if
// Valid/ready channel interfaces of the display RAM load sequencer.
// ----------------------------------------------------------------------------
interface drls_in_if import drls_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [7:0]          pixel_byte;
  logic [PosWidth-1:0] start_position;
  logic                first_of_run;
  logic                last_of_run;

  modport source (output valid, pixel_byte, start_position, first_of_run, last_of_run,
                  input ready);
  modport sink (input valid, pixel_byte, start_position, first_of_run, last_of_run,
                output ready);
endinterface

interface drls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_command;
  logic       end_of_burst;

  modport source (output valid, out_byte, is_command, end_of_burst, input ready);
  modport sink (input valid, out_byte, is_command, end_of_burst, output ready);
endinterface

interface drls_cfg_if;
  logic valid;
  logic ready;
  logic remap_segments;

  modport source (output valid, remap_segments, input ready);
  modport sink (input valid, remap_segments, output ready);
endinterface

### design/drls_front.sv
// ----------------------------------------------------------------------------
// drls_front
// Accepts image bytes, tracks the byte position and classifies each byte
// into a descriptor of the commands it needs.
// ----------------------------------------------------------------------------
module drls_front import drls_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  drls_in_if.sink       in_i,
  drls_cfg_if.sink      cfg_i,
  input  logic          push_ready_i,
  output logic          push_valid_o,
  output drls_desc_t    push_desc_o
);

  localparam int ImageBytes = COLUMNS * PAGES;

  logic [PosWidth-1:0]  pos_q, pos_d;
  logic                 remap_q;
  logic [PosWidth-1:0]  pos;
  logic [PosWidth-1:0]  base;
  logic [PosWidth:0]    pos_inc;
  logic [PageWidth-1:0] page;
  logic [ColWidth-1:0]  col;
  logic                 accept;

  assign cfg_i.ready  = 1'b1;
  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid && push_ready_i;
  assign push_valid_o = accept;

  always_comb begin
    if (in_i.first_of_run) begin
      pos = (int'(in_i.start_position) >= ImageBytes) ? '0 : in_i.start_position;
    end else begin
      pos = pos_q;
    end

    // page is the number of page boundaries at or below the position
    page = '0;
    base = '0;
    for (int k = 1; k < MaxPages; k++) begin
      if (k < PAGES && int'(pos) >= k * COLUMNS) begin
        page = PageWidth'(k);
        base = PosWidth'(k * COLUMNS);
      end
    end
    col = ColWidth'(pos - base);

    pos_inc = {1'b0, pos} + 1'b1;
    if (int'(pos_inc) >= ImageBytes || int'(pos_inc) >= PosLimit) begin
      pos_d = '0;
    end else begin
      pos_d = pos_inc[PosWidth-1:0];
    end
  end

  always_comb begin
    push_desc_o.pixel     = in_i.pixel_byte;
    push_desc_o.first     = in_i.first_of_run;
    push_desc_o.address   = in_i.first_of_run || (col == '0);
    push_desc_o.last      = in_i.last_of_run;
    push_desc_o.remap     = remap_q;
    push_desc_o.col_addr  = col + ColWidth'(AddrOffset);
    push_desc_o.page_addr = page + PageWidth'(AddrOffset);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      remap_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
      end
      if (cfg_i.valid) begin
        remap_q <= cfg_i.remap_segments;
      end
    end
  end

endmodule

### design/drls_queue.sv
// ----------------------------------------------------------------------------
// drls_queue
// Short descriptor queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module drls_queue import drls_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  drls_desc_t      push_desc_i,
  output logic            push_ready_o,
  output drls_desc_t      head_desc_o,
  input  drls_head_ctrl_t head_ctrl_i,
  output logic            head_valid_o
);

  drls_desc_t           entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 push, pop;

  assign push_ready_o = (int'(count_q) < QueueDepth);
  assign head_valid_o = (count_q != '0);
  assign head_desc_o  = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = head_ctrl_i.valid && head_ctrl_i.pop && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (int'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### design/drls_back.sv
// ----------------------------------------------------------------------------
// drls_back
// Expands each descriptor into its command and data bytes, one per cycle while
// the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module drls_back import drls_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  drls_desc_t      head_desc_i,
  output drls_head_ctrl_t head_ctrl_o,
  drls_out_if.source      out_o
);

  logic [NumSlots-1:0] mask_q;
  logic                started_q;
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                is_command_q;
  logic                end_q;

  logic [NumSlots-1:0] init_mask, pending, lowest, remaining;
  logic                load;
  logic [7:0]          res_byte;
  logic                res_cmd;

  assign out_o.valid        = out_valid_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.is_command   = is_command_q;
  assign out_o.end_of_burst = end_q;

  always_comb begin
    init_mask              = '0;
    init_mask[SlotRemap]   = head_desc_i.first;
    init_mask[SlotColHigh] = head_desc_i.address;
    init_mask[SlotColLow]  = head_desc_i.address;
    init_mask[SlotPage]    = head_desc_i.address;
    init_mask[SlotData]    = 1'b1;
    init_mask[SlotNop]     = head_desc_i.last;

    pending   = started_q ? mask_q : init_mask;
    lowest    = pending & (~pending + 1'b1);
    remaining = pending & ~lowest;
    load      = head_valid_i && (!out_valid_q || out_o.ready);

    res_cmd = 1'b1;
    if (lowest[SlotRemap]) begin
      res_byte = head_desc_i.remap ? CmdRemapOn : CmdRemapOff;
    end else if (lowest[SlotColHigh]) begin
      res_byte = CmdColHigh | {4'h0, head_desc_i.col_addr[7:4]};
    end else if (lowest[SlotColLow]) begin
      res_byte = CmdColLow | {4'h0, head_desc_i.col_addr[3:0]};
    end else if (lowest[SlotPage]) begin
      res_byte = CmdPage | {{(8 - PageWidth){1'b0}}, head_desc_i.page_addr};
    end else if (lowest[SlotData]) begin
      res_byte = head_desc_i.pixel;
      res_cmd  = 1'b0;
    end else begin
      res_byte = CmdNop;
    end

    head_ctrl_o.valid = load;
    head_ctrl_o.pop   = load && (remaining == '0);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q   <= res_byte;
      is_command_q <= res_cmd;
      end_q        <= (remaining == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      mask_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        // hold the slots still owed by the head item
        started_q   <= (remaining != '0);
        mask_q      <= remaining;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### design/display_ram_load_sequencer_unit.sv
// ----------------------------------------------------------------------------
// display_ram_load_sequencer_unit
// Image byte to display controller command/data stream sequencer.
// ----------------------------------------------------------------------------
// Each accepted image byte gives one to six output bytes: the segment remap
// command on the first byte of a run, the column-high, column-low and page
// commands when a run starts or a new row begins, the data byte, and a NOP
// command on the last byte of a run. One input item is accepted per cycle as
// long as the two-entry descriptor queue has room; the expansion stage sends
// one output byte per cycle while the output is ready, holding an item until
// all of its results are sent (one result for most bytes). The first result
// of an item passes through the descriptor queue and the registered output
// stage. The user must write the remap setting on the config channel while
// the block is idle (not enforced by the block); it takes effect for later items.
module display_ram_load_sequencer_unit import drls_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  drls_in_if.sink     in_i,
  drls_cfg_if.sink    cfg_i,
  drls_out_if.source  out_o
);

  logic            push_valid, push_ready, head_valid;
  drls_desc_t      push_desc, head_desc;
  drls_head_ctrl_t head_ctrl;

  drls_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_desc_o  (push_desc)
  );

  drls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_desc_i  (push_desc),
    .push_ready_o (push_ready),
    .head_desc_o  (head_desc),
    .head_ctrl_i  (head_ctrl),
    .head_valid_o (head_valid)
  );

  drls_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .head_ctrl_o  (head_ctrl),
    .out_o        (out_o)
  );

endmodule

### bench/display_ram_load_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// display_ram_load_sequencer_unit_tb
// Self-checking bench for the display RAM load sequencer. Image bytes are
// driven through directed cases and then random load runs and noise, under
// several idle and stall patterns and a long output hold-off. Every output
// byte is checked against the command/data stream predicted from each
// accepted image byte.
// ----------------------------------------------------------------------------
module display_ram_load_sequencer_unit_tb;
  import drls_pkg::*;

  localparam int Columns     = 128;
  localparam int Pages       = 4;
  localparam int ImageBytes  = Columns * Pages;
  localparam int DrainCycles = 8;
  localparam int MaxReports  = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       is_cmd;
    logic       burst_end;
  } ctrl_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  drls_in_if  in_if ();
  drls_out_if out_if ();
  drls_cfg_if cfg_if ();

  display_ram_load_sequencer_unit #(
    .COLUMNS(Columns),
    .PAGES  (Pages)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted sequencer state
  logic [PosWidth-1:0] next_position;
  logic                remap_setting;
  ctrl_byte_t          pending_ctrl_bytes[$];

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  int mismatch_count;
  int bytes_sent;
  int runs_sent;
  int ctrl_bytes_checked;
  int remap_writes;

  ctrl_byte_t seen_byte;
  ctrl_byte_t want_byte;

  function automatic int wrap_position(input int p);
    return (p >= ImageBytes || p >= PosLimit) ? 0 : p;
  endfunction

  function automatic void push_ctrl_byte(input logic [7:0] value, input logic is_cmd);
    ctrl_byte_t b;
    b.value     = value;
    b.is_cmd    = is_cmd;
    b.burst_end = 1'b0;
    pending_ctrl_bytes.push_back(b);
  endfunction

  // Expand one accepted image byte into the bytes it must produce
  function automatic void expand_image_byte(input logic [7:0] pixel,
                                            input logic [PosWidth-1:0] start,
                                            input logic first, input logic last);
    int         pos;
    int         col;
    int         page;
    ctrl_byte_t tail;
    if (first) begin
      pos = wrap_position(int'(start));
      push_ctrl_byte(remap_setting ? CmdRemapOn : CmdRemapOff, 1'b1);
    end else begin
      pos = wrap_position(int'(next_position));
    end
    col = pos % Columns + AddrOffset;
    if (first || col == AddrOffset) begin
      page = pos / Columns + AddrOffset;
      push_ctrl_byte(CmdColHigh | 8'(col / 16), 1'b1);
      push_ctrl_byte(CmdColLow | 8'(col % 16), 1'b1);
      push_ctrl_byte(CmdPage | 8'(page), 1'b1);
    end
    push_ctrl_byte(pixel, 1'b0);
    if (last) push_ctrl_byte(CmdNop, 1'b1);
    tail = pending_ctrl_bytes.pop_back();
    tail.burst_end = 1'b1;
    pending_ctrl_bytes.push_back(tail);
    next_position = PosWidth'(wrap_position(pos + 1));
  endfunction

  task automatic report_mismatch(input string what, input ctrl_byte_t want,
                                 input ctrl_byte_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("MISMATCH %s: expected byte %02h cmd %0b eob %0b, got byte %02h cmd %0b eob %0b",
               what, want.value, want.is_cmd, want.burst_end,
               got.value, got.is_cmd, got.burst_end);
    end
  endtask

  // Output checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_byte.value     = out_if.out_byte;
      seen_byte.is_cmd    = out_if.is_command;
      seen_byte.burst_end = out_if.end_of_burst;
      if (pending_ctrl_bytes.size() == 0) begin
        report_mismatch("unexpected output", '0, seen_byte);
      end else begin
        want_byte = pending_ctrl_bytes.pop_front();
        ctrl_bytes_checked++;
        if (seen_byte.value !== want_byte.value ||
            seen_byte.is_cmd !== want_byte.is_cmd ||
            seen_byte.burst_end !== want_byte.burst_end) begin
          report_mismatch("output byte", want_byte, seen_byte);
        end
      end
    end
  end

  // Output ready: random stalls, or a counted hold-off when requested
  always begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
    @(negedge clk_i);
  end

  task automatic send_image_byte(input logic [7:0] pixel, input logic [PosWidth-1:0] start,
                                 input logic first, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.pixel_byte     <= pixel;
    in_if.start_position <= start;
    in_if.first_of_run   <= first;
    in_if.last_of_run    <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expand_image_byte(pixel, start, first, last);
    bytes_sent++;
    if (first) runs_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid, then wait until every predicted byte has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_ctrl_bytes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_remap(input logic value);
    wait_drained();
    cfg_if.valid          <= 1'b1;
    cfg_if.remap_segments <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    remap_setting = value;
    remap_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_continue_after_reset();
    // No start seen yet: position 0 gives a row start
    send_image_byte(8'h00, 9'h1FF, 1'b0, 1'b0);
    send_image_byte(8'hFF, 9'h000, 1'b0, 1'b0);
    send_image_byte(8'h5A, 9'h155, 1'b0, 1'b1);
  endtask

  task automatic test_single_byte_runs();
    send_image_byte(8'h00, 9'd0, 1'b1, 1'b1);
    send_image_byte(8'hFF, 9'd511, 1'b1, 1'b1);
    send_image_byte(8'hA5, 9'd127, 1'b1, 1'b1);
    send_image_byte(8'h3C, 9'd256, 1'b1, 1'b1);
  endtask

  task automatic test_row_starts();
    send_image_byte(8'h11, 9'd126, 1'b1, 1'b0);
    send_image_byte(8'h22, 9'd0, 1'b0, 1'b0);
    send_image_byte(8'h33, 9'd0, 1'b0, 1'b0);
    send_image_byte(8'h44, 9'd0, 1'b0, 1'b0);
    send_image_byte(8'h55, 9'd383, 1'b1, 1'b0);
    send_image_byte(8'h66, 9'd0, 1'b0, 1'b1);
  endtask

  task automatic test_run_off_end();
    send_image_byte(8'h81, 9'd509, 1'b1, 1'b0);
    send_image_byte(8'h82, 9'd0, 1'b0, 1'b0);
    send_image_byte(8'h83, 9'd0, 1'b0, 1'b0);
    send_image_byte(8'h84, 9'd0, 1'b0, 1'b0);
    send_image_byte(8'h85, 9'd0, 1'b0, 1'b0);
    send_image_byte(8'h86, 9'd0, 1'b0, 1'b1);
  endtask

  task automatic test_remap_on();
    write_remap(1'b1);
    send_image_byte(8'hC3, 9'd384, 1'b1, 1'b1);
    send_image_byte(8'h7E, 9'd255, 1'b1, 1'b0);
    send_image_byte(8'h18, 9'd0, 1'b0, 1'b1);
    write_remap(1'b0);
  endtask

  task automatic send_random_run(input int limit);
    int run_len;
    int start;
    case ($urandom_range(3))
      0: start = $urandom_range(PosLimit - 1);
      1: start = $urandom_range(Pages - 1) * Columns + Columns - $urandom_range(1, 3);
      2: start = PosLimit - $urandom_range(1, 4);
      default: start = $urandom_range(Pages - 1) * Columns;
    endcase
    run_len = ($urandom_range(19) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 8);
    // Keep the run inside what is left of the phase
    if (run_len > limit) run_len = limit;
    for (int i = 0; i < run_len; i++) begin
      send_image_byte(8'($urandom), (i == 0) ? PosWidth'(start) : PosWidth'($urandom),
                      i == 0, i == run_len - 1);
    end
  endtask

  task automatic test_random_phase(input int goal, input int idle, input int stall);
    int phase_end;
    write_remap(1'($urandom_range(1)));
    send_idle_pct = idle;
    stall_pct     = stall;
    phase_end     = bytes_sent + goal;
    while (bytes_sent < phase_end) begin
      if ($urandom_range(99) < 15) begin
        send_image_byte(8'($urandom), PosWidth'($urandom), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
      end else begin
        send_random_run(phase_end - bytes_sent);
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  task automatic test_output_hold_off();
    wait_drained();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 300;
    // Keep offering while output is held so the queue fills up
    for (int i = 0; i < 30; i++) begin
      send_image_byte(8'($urandom), PosWidth'($urandom), i % 7 == 0, i % 7 == 6);
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.pixel_byte      = '0;
    in_if.start_position  = '0;
    in_if.first_of_run    = 1'b0;
    in_if.last_of_run     = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.remap_segments = 1'b0;
    next_position         = '0;
    remap_setting         = 1'b0;
    send_idle_pct         = 0;
    stall_pct             = 0;
    hold_left             = 0;
    mismatch_count        = 0;
    bytes_sent            = 0;
    runs_sent             = 0;
    ctrl_bytes_checked    = 0;
    remap_writes          = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_continue_after_reset();
    test_single_byte_runs();
    test_row_starts();
    test_run_off_end();
    test_remap_on();
    test_random_phase(85, 0, 0);
    test_random_phase(85, 72, 0);
    test_random_phase(85, 0, 72);
    test_random_phase(85, 33, 33);
    test_output_hold_off();
    write_remap(1'b1);
    test_random_phase(20, 10, 10);

    wait_drained();
    if (pending_ctrl_bytes.size() != 0) mismatch_count++;
    $display("Covered %0d image bytes in %0d runs, %0d output bytes checked, %0d remap writes",
             bytes_sent, runs_sent, ctrl_bytes_checked, remap_writes);
    $display("Phases: no idling, sender idle, receiver stall, both, long output hold-off");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timeout with %0d output bytes outstanding", pending_ctrl_bytes.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
